FILE: hw/rtl/dup_copy_param_record_loader_top_macros.svh
// Assertion macros for the duplicate-copy parameter record loader
`ifndef DUP_COPY_PARAM_RECORD_LOADER_TOP_MACROS_SVH
`define DUP_COPY_PARAM_RECORD_LOADER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DCPRL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dcprl: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define DCPRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcprl: next-cycle check failed");

`endif

FILE: hw/rtl/dcprl_pkg.sv
// Shared types and constants for the parameter record loader
`timescale 1ns / 1ps
`default_nettype none
package dcprl_pkg;

	localparam int INT_PARAM_COUNT   = 64;
	localparam int FLOAT_PARAM_COUNT = 128;

	localparam int WORD_W    = 16;
	localparam int IDX_W     = 10;
	localparam int VALUE_W   = 32;
	localparam int SUM_W     = 32;
	localparam int CFG_IDX_W = 8;
	localparam int NUM_HDR   = 4;

	typedef enum logic [1:0] {
		KIND_INT   = 2'd0,
		KIND_FLOAT = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [IDX_W-1:0]    index;
		logic [VALUE_W-1:0]  value;
		logic                ok;
	} result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dcprl_parser.sv
// Record parser: header check, copy compare, checksum, config registers
`timescale 1ns / 1ps
`default_nettype none
module dcprl_parser (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [dcprl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [dcprl_pkg::WORD_W-1:0]         cfg_data,
	input  wire                                 in_fire,
	input  wire [dcprl_pkg::WORD_W-1:0]         flash_word,
	input  wire                                 record_start,
	output logic                                res_valid,
	output dcprl_pkg::result_t                  res
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_INT    = 3'd2,
		PH_FLOAT  = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	localparam logic [dcprl_pkg::IDX_W-1:0] INT_LAST =
		dcprl_pkg::IDX_W'(dcprl_pkg::INT_PARAM_COUNT - 1);
	localparam logic [dcprl_pkg::IDX_W-1:0] FLOAT_LAST =
		dcprl_pkg::IDX_W'(dcprl_pkg::FLOAT_PARAM_COUNT - 1);

	phase_t                          phase_q, phase_n;
	logic [dcprl_pkg::IDX_W-1:0]     cnt_q, cnt_n;
	logic [1:0]                      slot_q, slot_n;
	logic [dcprl_pkg::WORD_W-1:0]    held_q [3];
	logic [dcprl_pkg::WORD_W-1:0]    held_n [3];
	logic [dcprl_pkg::SUM_W-1:0]     sum_q, sum_n;
	logic                            failed_q, failed_n;
	logic [dcprl_pkg::WORD_W-1:0]    hdr_q [dcprl_pkg::NUM_HDR];
	logic [dcprl_pkg::WORD_W-1:0]    chk_expect;

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		slot_n    = slot_q;
		held_n    = held_q;
		sum_n     = sum_q;
		failed_n  = failed_q;
		res_valid = 1'b0;
		res       = '0;
		case (slot_q)
			2'd0:    chk_expect = sum_q[dcprl_pkg::WORD_W-1:0];
			2'd1:    chk_expect = sum_q[dcprl_pkg::SUM_W-1:dcprl_pkg::WORD_W];
			default: chk_expect = '0;
		endcase
		if (in_fire) begin
			if (record_start) begin
				phase_n  = PH_HEADER;
				cnt_n    = '0;
				slot_n   = '0;
				held_n   = '{default: '0};
				sum_n    = '0;
				failed_n = 1'b0;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (flash_word != hdr_q[slot_q]) begin
							res_valid = 1'b1;
							res.kind  = dcprl_pkg::KIND_DONE;
							phase_n   = PH_IDLE;
							slot_n    = '0;
						end else if (slot_q == 2'd3) begin
							phase_n = PH_INT;
							slot_n  = '0;
							cnt_n   = '0;
						end else begin
							slot_n = slot_q + 2'd1;
						end
					end
					PH_INT: begin
						if (slot_q == 2'd0) begin
							held_n[0] = flash_word;
							sum_n     = sum_q + dcprl_pkg::SUM_W'(flash_word);
							slot_n    = 2'd1;
						end else begin
							if (flash_word == held_q[0]) begin
								res_valid = 1'b1;
								res.kind  = dcprl_pkg::KIND_INT;
								res.index = cnt_q;
								res.value = dcprl_pkg::VALUE_W'(held_q[0]);
							end else begin
								failed_n = 1'b1;
							end
							slot_n = '0;
							if (cnt_q == INT_LAST) begin
								phase_n = PH_FLOAT;
								cnt_n   = '0;
							end else begin
								cnt_n = cnt_q + 1'b1;
							end
						end
					end
					PH_FLOAT: begin
						case (slot_q)
							2'd0, 2'd1: begin
								held_n[slot_q] = flash_word;
								sum_n  = sum_q + dcprl_pkg::SUM_W'(flash_word);
								slot_n = slot_q + 2'd1;
							end
							2'd2: begin
								held_n[2] = flash_word;
								slot_n    = 2'd3;
							end
							default: begin
								if (held_q[2] == held_q[0] && flash_word == held_q[1]) begin
									res_valid = 1'b1;
									res.kind  = dcprl_pkg::KIND_FLOAT;
									res.index = cnt_q;
									res.value = {held_q[1], held_q[0]};
								end else begin
									failed_n = 1'b1;
								end
								slot_n = '0;
								if (cnt_q == FLOAT_LAST) begin
									phase_n = PH_CHECK;
									cnt_n   = '0;
								end else begin
									cnt_n = cnt_q + 1'b1;
								end
							end
						endcase
					end
					PH_CHECK: begin
						if (flash_word != chk_expect) begin
							failed_n = 1'b1;
						end
						if (slot_q == 2'd3) begin
							res_valid = 1'b1;
							res.kind  = dcprl_pkg::KIND_DONE;
							res.ok    = ~failed_n;
							phase_n   = PH_IDLE;
							slot_n    = '0;
						end else begin
							slot_n = slot_q + 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			slot_q   <= '0;
			held_q   <= '{default: '0};
			sum_q    <= '0;
			failed_q <= 1'b0;
			hdr_q    <= '{default: '0};
		end else begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			slot_q   <= slot_n;
			held_q   <= held_n;
			sum_q    <= sum_n;
			failed_q <= failed_n;
			if (cfg_we && cfg_index < dcprl_pkg::CFG_IDX_W'(dcprl_pkg::NUM_HDR)) begin
				hdr_q[cfg_index[1:0]] <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/dcprl_out_buf.sv
// Result register with skid stage
`timescale 1ns / 1ps
`default_nettype none
module dcprl_out_buf (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire dcprl_pkg::result_t  push_data,
	output logic                     space,
	output logic                     out_valid,
	input  wire                      out_ready,
	output dcprl_pkg::result_t       out_data
);

	dcprl_pkg::result_t  skid_q;
	logic                skid_valid_q;
	logic                pop;

	assign pop   = out_valid & out_ready;
	assign space = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid || pop) begin
				if (skid_valid_q) begin
					out_valid    <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || pop) begin
			out_data <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/dup_copy_param_record_loader_top.sv
// Top level of the duplicate-copy parameter record loader
// Usage:
//   Input channel (in_valid/in_ready) takes one 16-bit flash word per request;
//   record_start marks the dummy word that opens a record and restarts parsing.
//   Output channel (out_valid/out_ready) carries parameter writes (integer or
//   float, with table index and value) and at most one finish request per record with
//   record_ok. Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   the four expected header words at indexes 0 to 3; others are dropped.
//   Output: a result is registered into the output register, or into the skid
//   stage while the output waits. Throughput: one word per cycle while in_ready
//   is high, set by the single compare-and-add stage feeding the result register.
//   Stall: a two-entry result register and skid stage let the input keep
//   taking words while one result waits; in_ready drops only when both hold.
//   Reset: parser returns to idle, header registers clear to zero, both
//   output entries empty. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "dup_copy_param_record_loader_top_macros.svh"
module dup_copy_param_record_loader_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [dcprl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [dcprl_pkg::WORD_W-1:0]         cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [dcprl_pkg::WORD_W-1:0]         flash_word,
	input  wire                                 record_start,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [1:0]                          result_kind,
	output logic [dcprl_pkg::IDX_W-1:0]         param_index,
	output logic [dcprl_pkg::VALUE_W-1:0]       param_value,
	output logic                                record_ok
);

	logic                in_fire;
	logic                res_valid;
	dcprl_pkg::result_t  res;
	dcprl_pkg::result_t  out_data;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;

	dcprl_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_fire      (in_fire),
		.flash_word   (flash_word),
		.record_start (record_start),
		.res_valid    (res_valid),
		.res          (res)
	);

	dcprl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign result_kind = out_data.kind;
	assign param_index = out_data.index;
	assign param_value = out_data.value;
	assign record_ok   = out_data.ok;

	`DCPRL_ASSERT_IMPL(a_full_implies_out, !in_ready, out_valid)
	`DCPRL_ASSERT_IMPL(a_done_zero_payload, out_valid && result_kind == dcprl_pkg::KIND_DONE, param_index == '0 && param_value == '0)
	`DCPRL_ASSERT_IMPL(a_write_not_ok, out_valid && result_kind != dcprl_pkg::KIND_DONE, !record_ok)
	`DCPRL_ASSERT_NEXT(a_start_no_result, in_valid && in_ready && record_start && out_ready && !out_valid, !out_valid)

endmodule
`default_nettype wire

FILE: verif/dup_copy_param_record_loader_top_tb.sv
// Self-checking testbench: stored parameter records against a word-level predictor
`timescale 1ns / 1ps
module dup_copy_param_record_loader_top_tb;
	import dcprl_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_TARGET = 1700;
	localparam int PRINT_CAP   = 40;

	localparam logic [CFG_IDX_W-1:0] REG_HDR_0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_3 = 8'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_INT,
		PH_FLOAT,
		PH_CHECK
	} parse_phase_t;

	typedef enum int {
		HDR_ZERO,
		HDR_ONES,
		HDR_CHECKER,
		HDR_RANDOM
	} hdr_setting_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              start;
		logic              fixed;
		result_t           want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [WORD_W-1:0]      cfg_data     = '0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [WORD_W-1:0]      flash_word   = '0;
	logic                   record_start = 1'b0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [1:0]             result_kind;
	logic [IDX_W-1:0]       param_index;
	logic [VALUE_W-1:0]     param_value;
	logic                   record_ok;

	dup_copy_param_record_loader_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.flash_word   (flash_word),
		.record_start (record_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.param_index  (param_index),
		.param_value  (param_value),
		.record_ok    (record_ok)
	);

	// parser copy
	logic [WORD_W-1:0] hdr_cfg [NUM_HDR];
	parse_phase_t      parse_ph  = PH_IDLE;
	logic [10:0]       param_cnt = '0;
	logic [1:0]        word_pos  = '0;
	logic [WORD_W-1:0] held [3];
	logic [SUM_W-1:0]  first_sum = '0;
	logic              rec_bad   = 1'b0;

	result_t           due_results [$];
	logic [WORD_W-1:0] rec_words [$];
	stim_row_t         dir_rows [$];

	int mismatch_cnt = 0;
	int fed_items    = 0;
	int cycle_cnt    = 0;
	int rx_wait      = 0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic bit parse_word(input logic [WORD_W-1:0] w, input logic s,
		output result_t r);
		logic [WORD_W-1:0] chk;
		bit fire;
		fire = 1'b0;
		r = '0;
		if (s) begin
			parse_ph = PH_HEADER;
			param_cnt = '0;
			word_pos = '0;
			held[0] = '0;
			held[1] = '0;
			held[2] = '0;
			first_sum = '0;
			rec_bad = 1'b0;
			return 1'b0;
		end
		case (parse_ph)
			PH_HEADER: begin
				if (w != hdr_cfg[word_pos]) begin
					r.kind = KIND_DONE;
					fire = 1'b1;
					parse_ph = PH_IDLE;
					word_pos = '0;
				end else if (word_pos == 2'd3) begin
					parse_ph = PH_INT;
					word_pos = '0;
					param_cnt = '0;
				end else begin
					word_pos++;
				end
			end
			PH_INT: begin
				if (word_pos == 2'd0) begin
					held[0] = w;
					first_sum += SUM_W'(w);
					word_pos = 2'd1;
				end else begin
					if (w == held[0]) begin
						r.kind = KIND_INT;
						r.index = param_cnt[IDX_W-1:0];
						r.value = {16'h0000, held[0]};
						fire = 1'b1;
					end else begin
						rec_bad = 1'b1;
					end
					word_pos = '0;
					param_cnt++;
					if (param_cnt >= INT_PARAM_COUNT) begin
						parse_ph = PH_FLOAT;
						param_cnt = '0;
					end
				end
			end
			PH_FLOAT: begin
				if (word_pos < 2'd2) begin
					held[word_pos] = w;
					first_sum += SUM_W'(w);
					word_pos++;
				end else if (word_pos == 2'd2) begin
					held[2] = w;
					word_pos = 2'd3;
				end else begin
					if (held[2] == held[0] && w == held[1]) begin
						r.kind = KIND_FLOAT;
						r.index = param_cnt[IDX_W-1:0];
						r.value = {held[1], held[0]};
						fire = 1'b1;
					end else begin
						rec_bad = 1'b1;
					end
					word_pos = '0;
					param_cnt++;
					if (param_cnt >= FLOAT_PARAM_COUNT) begin
						parse_ph = PH_CHECK;
						param_cnt = '0;
					end
				end
			end
			PH_CHECK: begin
				if (word_pos == 2'd0)
					chk = first_sum[15:0];
				else if (word_pos == 2'd1)
					chk = first_sum[31:16];
				else
					chk = '0;
				if (w != chk)
					rec_bad = 1'b1;
				if (word_pos == 2'd3) begin
					r.kind = KIND_DONE;
					r.ok = !rec_bad;
					fire = 1'b1;
					parse_ph = PH_IDLE;
					word_pos = '0;
				end else begin
					word_pos++;
				end
			end
			default: ;
		endcase
		return fire;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_cnt < PRINT_CAP)
			$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result, kind", 32'(result_kind), 32'd0);
			end else begin
				want = due_results.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
				if (param_index !== want.index)
					report_mismatch("param_index", 32'(param_index), 32'(want.index));
				if (param_value !== want.value)
					report_mismatch("param_value", param_value, want.value);
				if (record_ok !== want.ok)
					report_mismatch("record_ok", 32'(record_ok), 32'(want.ok));
			end
		end
	end

	always @(posedge clk) begin : drain_side
		int stall;
		if (arst_n) begin
			if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				if (rx_wait == 1)
					out_ready <= 1'b1;
			end else if (out_valid && out_ready) begin
				stall = rx_burst ? 0 : $urandom_range(0, 6);
				if (stall != 0) begin
					out_ready <= 1'b0;
					rx_wait <= stall;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return WORD_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] spoil(input logic [WORD_W-1:0] w, input bit dirty);
		logic [WORD_W-1:0] m;
		m = WORD_W'($urandom_range(1, 65535));
		if (dirty && $urandom_range(0, 19) == 0)
			return w ^ m;
		return w;
	endfunction

	function automatic stim_row_t mk_row(input logic [WORD_W-1:0] w, input logic s,
		input logic fixed, input kind_t k, input logic [IDX_W-1:0] idx,
		input logic [VALUE_W-1:0] v, input logic ok);
		stim_row_t row;
		row.word = w;
		row.start = s;
		row.fixed = fixed;
		row.want.kind = k;
		row.want.index = idx;
		row.want.value = v;
		row.want.ok = ok;
		return row;
	endfunction

	task automatic push_word(input logic [WORD_W-1:0] w, input logic s, input bit fixed,
		input result_t fixed_res);
		int gap;
		result_t r;
		bit got;
		gap = tx_burst ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		flash_word <= w;
		record_start <= s;
		do @(posedge clk); while (!in_ready);
		if (s || parse_ph != PH_IDLE)
			fed_items++;
		got = parse_word(w, s, r);
		if (fixed)
			due_results.push_back(fixed_res);
		else if (got)
			due_results.push_back(r);
	endtask

	task automatic send_words(input int n);
		int i;
		for (i = 0; i < n; i++)
			push_word(rec_words[i], i == 0, 1'b0, '0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d,
		input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HDR_0: hdr_cfg[0] = d;
			REG_HDR_1: hdr_cfg[1] = d;
			REG_HDR_2: hdr_cfg[2] = d;
			REG_HDR_3: hdr_cfg[3] = d;
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic load_setting(input hdr_setting_t how);
		logic [WORD_W-1:0] v [NUM_HDR];
		int i;
		for (i = 0; i < NUM_HDR; i++) begin
			case (how)
				HDR_ZERO:    v[i] = 16'h0000;
				HDR_ONES:    v[i] = 16'hFFFF;
				HDR_CHECKER: v[i] = i[0] ? 16'h5555 : 16'hAAAA;
				default:     v[i] = rand_word();
			endcase
		end
		write_reg(REG_HDR_0, v[0], 1'b0);
		write_reg(REG_HDR_1, v[1], 1'b0);
		write_reg(REG_HDR_2, v[2], 1'b0);
		write_reg(REG_HDR_3, v[3], 1'b0);
		// out-of-range index, must be dropped
		write_reg(CFG_IDX_W'($urandom_range(NUM_HDR, 255)),
			WORD_W'($urandom_range(0, 65535)), 1'b1);
	endtask

	task automatic build_record(input bit dirty);
		logic [SUM_W-1:0] total;
		logic [WORD_W-1:0] a, b;
		int i;
		rec_words.delete();
		total = '0;
		rec_words.push_back(rand_word());
		for (i = 0; i < NUM_HDR; i++)
			rec_words.push_back(hdr_cfg[i]);
		for (i = 0; i < INT_PARAM_COUNT; i++) begin
			a = rand_word();
			total += SUM_W'(a);
			rec_words.push_back(a);
			rec_words.push_back(spoil(a, dirty));
		end
		for (i = 0; i < FLOAT_PARAM_COUNT; i++) begin
			a = rand_word();
			b = rand_word();
			total += SUM_W'(a);
			total += SUM_W'(b);
			rec_words.push_back(a);
			rec_words.push_back(b);
			rec_words.push_back(spoil(a, dirty));
			rec_words.push_back(spoil(b, dirty));
		end
		rec_words.push_back(spoil(total[15:0], dirty));
		rec_words.push_back(spoil(total[31:16], dirty));
		rec_words.push_back(spoil(16'h0000, dirty));
		rec_words.push_back(spoil(16'h0000, dirty));
	endtask

	initial begin : stimulus
		int i, n, pick, k;
		logic [WORD_W-1:0] m;
		for (i = 0; i < NUM_HDR; i++)
			hdr_cfg[i] = '0;

		dir_rows.push_back(mk_row(16'hFFFF, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h0000, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'hFFFF, 1'b1, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h0000, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'hFFFF, 1'b0, 1'b1, KIND_DONE, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h1234, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h0000, 1'b1, 1'b0, KIND_INT, '0, '0, 1'b0));
		for (i = 0; i < NUM_HDR; i++)
			dir_rows.push_back(mk_row(16'h0000, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'hFFFF, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'hFFFF, 1'b0, 1'b1, KIND_INT, '0, 32'h0000FFFF, 1'b0));
		dir_rows.push_back(mk_row(16'h0000, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h0001, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'hAAAA, 1'b1, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h5555, 1'b0, 1'b1, KIND_DONE, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h8000, 1'b1, 1'b0, KIND_INT, '0, '0, 1'b0));
		for (i = 0; i < 3; i++)
			dir_rows.push_back(mk_row(16'h0000, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h8000, 1'b0, 1'b1, KIND_DONE, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(16'h7FFF, 1'b0, 1'b0, KIND_INT, '0, '0, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_word(dir_rows[i].word, dir_rows[i].start, dir_rows[i].fixed,
				dir_rows[i].want);

		wait_idle();
		load_setting(HDR_ONES);

		while (fed_items < ITEM_TARGET) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				load_setting(hdr_setting_t'($urandom_range(0, 3)));
			end
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				build_record(pick >= 2);
				send_words(rec_words.size());
			end else if (pick < 7) begin
				// cut short, the next request with record_start abandons it
				build_record(1'b1);
				send_words($urandom_range(2, rec_words.size() - 1));
			end else if (pick < 9) begin
				k = $urandom_range(0, NUM_HDR - 1);
				build_record(1'b0);
				m = WORD_W'($urandom_range(1, 65535));
				rec_words[1 + k] = rec_words[1 + k] ^ m;
				send_words(2 + k + $urandom_range(0, 3));
			end else begin
				n = $urandom_range(1, 12);
				for (i = 0; i < n; i++)
					push_word(rand_word(), $urandom_range(0, 7) == 0, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
